FILE: hw/rtl/hte_pkg.sv
// hte_pkg: shared types, character constants and helper functions
// for the backtick hex text escaper; no dependencies
package hte_pkg;

   localparam logic [7:0] CH_ESC   = 8'h60;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TILDE = 8'h7E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UZ    = 8'h5A;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LZ    = 8'h7A;
   localparam logic [7:0] CH_UNDER = 8'h5F;

   localparam int NUM_SLOTS = 7;

   // output slots of one item, in emission order
   typedef enum logic [2:0] {
      SLOT_SPACE,
      SLOT_OPEN,
      SLOT_LIT,
      SLOT_ESC,
      SLOT_HI,
      SLOT_LO,
      SLOT_CLOSE
   } slot_type;

   typedef struct packed {
      logic [NUM_SLOTS-1:0] slots;
      logic [7:0]           ch;
   } job_type;

   function automatic logic passes_name(input logic [7:0] c, input logic opening);
      logic alpha;
      logic digit;
      alpha = (c >= CH_UA && c <= CH_UZ) || (c >= CH_LA && c <= CH_LZ) || (c == CH_UNDER);
      digit = (c >= CH_ZERO && c <= CH_NINE);
      return alpha || (!opening && digit);
   endfunction

   function automatic logic passes_string(input logic [7:0] c);
      return (c >= CH_SPACE) && (c <= CH_TILDE) && (c != CH_QUOTE) && (c != CH_ESC);
   endfunction

   function automatic logic [7:0] hex_digit(input logic [3:0] n);
      logic [7:0] wide;
      wide = {4'd0, n};
      return (n < 4'd10) ? (CH_ZERO + wide) : (CH_LA - 8'd10 + wide);
   endfunction

endpackage

FILE: hw/rtl/hte_front.sv
// hte_front: accepts input transactions, tracks the buffer non-empty flag
// and classifies each item into a slot mask; depends on hte_pkg
module hte_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic            func,
   input  logic [7:0]      ch,
   input  logic            first,
   input  logic            last,
   input  logic            no_char,
   input  logic            new_buffer,
   input  logic            queue_full,
   output logic            push,
   output hte_pkg::job_type job
);
   import hte_pkg::*;

   logic nonempty_ff;
   logic nonempty_in;
   logic ne;
   logic pass;
   logic accept;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;
   assign ne        = nonempty_ff && !new_buffer;
   assign pass      = func ? passes_string(ch) : passes_name(ch, first);

   always_comb begin
      job.ch                = ch;
      job.slots             = '0;
      job.slots[SLOT_SPACE] = first && ne;
      job.slots[SLOT_OPEN]  = first && func;
      job.slots[SLOT_LIT]   = !no_char && pass;
      job.slots[SLOT_ESC]   = !no_char && !pass;
      job.slots[SLOT_HI]    = !no_char && !pass;
      job.slots[SLOT_LO]    = !no_char && !pass;
      job.slots[SLOT_CLOSE] = last && func;
   end

   assign push        = accept && (|job.slots);
   assign nonempty_in = accept ? ((|job.slots) || ne) : nonempty_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nonempty_ff <= 1'b0;
      end else begin
         nonempty_ff <= nonempty_in;
      end
   end

endmodule

FILE: hw/rtl/hte_fifo.sv
// hte_fifo: short job queue between front and back
// depends on hte_pkg for the job type
module hte_fifo #(
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hte_pkg::job_type push_data,
   output logic             full,
   input  logic             pop,
   output hte_pkg::job_type head,
   output logic             empty
);
   import hte_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

   job_type       mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push;
   logic          do_pop;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/hte_back.sv
// hte_back: walks the queue head's slot mask, one output byte per cycle unless
// stalled, into a registered output stage; depends on hte_pkg
module hte_back (
   input  logic             clock,
   input  logic             reset,
   input  hte_pkg::job_type head,
   input  logic             queue_empty,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_data,
   output logic             rsp_last
);
   import hte_pkg::*;

   logic [NUM_SLOTS-1:0] done_ff, done_in;
   logic                 valid_ff, valid_in;
   logic [7:0]           data_ff, data_in;
   logic                 last_ff, last_in;
   logic [NUM_SLOTS-1:0] pending;
   logic [NUM_SLOTS-1:0] sel_mask;
   logic                 is_last;
   logic                 load;
   slot_type             sel;
   logic [7:0]           byte_val;

   assign pending  = head.slots & ~done_ff;
   assign sel_mask = pending & ~(pending - NUM_SLOTS'(1));
   assign is_last  = ((pending & ~sel_mask) == '0);
   assign load     = !queue_empty && (!valid_ff || rsp_ready);
   assign pop      = load && is_last;

   always_comb begin
      sel = SLOT_SPACE;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (pending[i]) begin
            sel = slot_type'(i[2:0]);
         end
      end
   end

   always_comb begin
      unique case (sel)
         SLOT_SPACE: byte_val = CH_SPACE;
         SLOT_OPEN:  byte_val = CH_QUOTE;
         SLOT_LIT:   byte_val = head.ch;
         SLOT_ESC:   byte_val = CH_ESC;
         SLOT_HI:    byte_val = hex_digit(head.ch[7:4]);
         SLOT_LO:    byte_val = hex_digit(head.ch[3:0]);
         SLOT_CLOSE: byte_val = CH_QUOTE;
         default:    byte_val = '0;
      endcase
   end

   always_comb begin
      done_in  = done_ff;
      valid_in = valid_ff;
      data_in  = data_ff;
      last_in  = last_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      if (load) begin
         valid_in = 1'b1;
         data_in  = byte_val;
         last_in  = is_last;
         done_in  = is_last ? '0 : (done_ff | sel_mask);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
   assign rsp_last  = last_ff;

endmodule

FILE: hw/rtl/backtick_hex_text_escaper.sv
// Backtick hex text escaper. Each accepted item turns into 0 to 6 output
// bytes: an optional space, an optional opening quote, the byte itself or a
// backtick and two lowercase hex digits, and an optional closing quote. The
// back end sends one output byte per cycle while the output is not stalled;
// a plain escaped byte produces three output bytes, and items that produce
// nothing are never queued. The front end takes one item per cycle while the
// job queue (QUEUE_DEPTH entries) has room; a registered output stage lets the
// next byte load in the same cycle that the current one is taken.
// Depends on hte_pkg, hte_front, hte_fifo and hte_back.
module backtick_hex_text_escaper #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // ch[7:0], first[8], new_buffer[9], zero[15:10]
   input  logic [1:0]  req_tuser,  // func[0], no_char[1]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,  // out_byte[7:0]
   output logic        rsp_tlast
);
   import hte_pkg::*;

   job_type job;
   job_type head;
   logic    push;
   logic    pop;
   logic    queue_full;
   logic    queue_empty;

   hte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_tvalid),
      .req_ready  (req_tready),
      .func       (req_tuser[0]),
      .ch         (req_tdata[7:0]),
      .first      (req_tdata[8]),
      .last       (req_tlast),
      .no_char    (req_tuser[1]),
      .new_buffer (req_tdata[9]),
      .queue_full (queue_full),
      .push       (push),
      .job        (job)
   );

   hte_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (job),
      .full      (queue_full),
      .pop       (pop),
      .head      (head),
      .empty     (queue_empty)
   );

   hte_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .queue_empty (queue_empty),
      .pop         (pop),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_data    (rsp_tdata),
      .rsp_last    (rsp_tlast)
   );

endmodule

FILE: hw/rtl/hte_checker.sv
// hte_checker: port-level assertions for the escaper, bound to the top level
// depends on hte_pkg and backtick_hex_text_escaper
module hte_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast
);
   import hte_pkg::*;

   // output idle right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   // stalled transaction holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled output changed");

   // a backtick only ever opens an escape, never ends an item
   a_esc_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata == CH_ESC |-> !rsp_tlast)
      else $error("escape marker marked as last");

   // escape marker is followed at once by a hex digit
   a_esc_hex: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tdata == CH_ESC |=>
         rsp_tvalid && ((rsp_tdata >= CH_ZERO && rsp_tdata <= CH_NINE) ||
                        (rsp_tdata >= CH_LA && rsp_tdata <= 8'h66)))
      else $error("escape marker not followed by hex digit");

endmodule

bind backtick_hex_text_escaper hte_checker u_hte_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
